[sv/woram_pkg.sv]
// ----------------------------------------------------------------------------
// woram_pkg: shared definitions for the write-only ORAM placement engine
// Transaction types, operation and action codes, generator constants and
// the default sizes handed to the top level.
// ----------------------------------------------------------------------------
package woram_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned LOGICAL_BLOCKS_DEF  = 8;
  localparam int unsigned PHYSICAL_BLOCKS_DEF = 24;
  localparam int unsigned TOUCH_COUNT_DEF     = 10;

  // Field widths fixed by the transaction format.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned LB_W    = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned SEED_W  = 64;
  localparam int unsigned HALF_W  = SEED_W / 2;

  // Operation codes of an input transaction.
  localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

  // Action codes of a result transaction.
  localparam logic [ACT_W-1:0] ACT_NEW    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_KEEP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ZERO   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd3;

  // xorshift64* generator.
  localparam logic [SEED_W-1:0] SEED_RESET = 64'd1;
  localparam logic [SEED_W-1:0] MULT_CONST = 64'h2545_F491_4F6C_DD1D;
  localparam int unsigned       SHIFT_A    = 12;
  localparam int unsigned       SHIFT_B    = 25;
  localparam int unsigned       SHIFT_C    = 27;

  // Sampling gives up after this many generator draws.
  localparam int unsigned DRAW_LIMIT = 1024;
  localparam int unsigned TRY_W      = $clog2(DRAW_LIMIT + 1);

  // Residue unit consumes the generator output one byte per cycle.
  localparam int unsigned DIGIT_W = 8;
  localparam int unsigned DIGITS  = SEED_W / DIGIT_W;
  localparam int unsigned DCW     = $clog2(DIGITS);

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [LB_W-1:0] logical_block;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [ACT_W-1:0]  action;
    logic [SEED_W-1:0] nonce;
    logic              mapped;
    logic              last;
  } out_item_t;

  // Commands from the sequencer to the generator.
  typedef struct packed {
    logic start;
    logic load;
  } rng_ctl_t;

endpackage

[sv/write_only_oram_placement.sv]
// ----------------------------------------------------------------------------
// write_only_oram_placement: placement engine of a write-only ORAM
// Draws distinct physical positions for each logical write, keeps the
// logical-to-physical map and occupancy, and issues per-position actions.
// ----------------------------------------------------------------------------
// Usage:
//   The configuration channel (cfg_*) loads the seed register; it is always
//   ready, and the user must write it only while the engine is idle (the
//   engine does not enforce this). Input transactions carry an op and a
//   logical block. A restart reloads the generator from the seed and clears
//   map and occupancy. A lookup's result is loaded into the output register
//   once it has room. A write yields one result per drawn position in draw
//   order, the last one flagged; ops with code 3 and out-of-range blocks are
//   dropped without a result.
//   Flow: the engine takes one input transaction at a time. Each draw runs
//   the generator (over a shared 32x32 multiplier) and then the modulo unit
//   (a load, then one byte per cycle of the generator output). Each result
//   takes a drawn-RAM read, a generator step and an output register load.
//   Results sit in an output register; while the receiver stalls, the
//   engine waits with the next result, and once the last result of an item
//   is in the register it takes the next input.
//   Reset loads the seed register with 1 and the generator with that value,
//   and clears the map valid bits and the occupancy bits.
// ----------------------------------------------------------------------------
module write_only_oram_placement #(
  parameter int unsigned LOGICAL_BLOCKS  = woram_pkg::LOGICAL_BLOCKS_DEF,
  parameter int unsigned PHYSICAL_BLOCKS = woram_pkg::PHYSICAL_BLOCKS_DEF,
  parameter int unsigned TOUCH_COUNT     = woram_pkg::TOUCH_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [woram_pkg::SEED_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  woram_pkg::in_item_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output woram_pkg::out_item_t         out_data_o
);
  import woram_pkg::*;

  localparam int unsigned PW     = $clog2(PHYSICAL_BLOCKS);
  localparam int unsigned TARGET = (TOUCH_COUNT < PHYSICAL_BLOCKS) ? TOUCH_COUNT
                                                                    : PHYSICAL_BLOCKS;
  localparam int unsigned CW     = $clog2(TARGET + 1);
  localparam int unsigned IW     = $clog2(TARGET);
  localparam int unsigned LAW    = (LOGICAL_BLOCKS > 1) ? $clog2(LOGICAL_BLOCKS) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOOK     = 4'd1;
  localparam logic [3:0] S_DRAW_RNG = 4'd2;
  localparam logic [3:0] S_DRAW_MOD = 4'd3;
  localparam logic [3:0] S_PLACE    = 4'd4;
  localparam logic [3:0] S_EMIT_RD  = 4'd5;
  localparam logic [3:0] S_EMIT_RNG = 4'd6;
  localparam logic [3:0] S_EMIT_OUT = 4'd7;

  logic [3:0]                 state_q, state_d;
  logic [SEED_W-1:0]          seed_q;
  logic [LAW-1:0]             lb_addr_q, lb_addr_d;
  logic [LOGICAL_BLOCKS-1:0]  map_valid_q, map_valid_d;
  logic [PHYSICAL_BLOCKS-1:0] occupied_q, occupied_d;
  logic [PHYSICAL_BLOCKS-1:0] drawn_q, drawn_d;
  logic [CW-1:0]              draw_cnt_q, draw_cnt_d;
  logic [CW-1:0]              emit_idx_q, emit_idx_d;
  logic [TRY_W-1:0]           tries_q, tries_d;
  logic                       ff_valid_q, ff_valid_d;
  logic [PW-1:0]              ff_q, ff_d;
  logic                       have_q, have_d;
  logic [PW-1:0]              home_q, home_d;
  logic                       out_valid_q, out_valid_d;
  out_item_t                  out_q, out_d;
  logic                       out_load;
  logic                       slot_free;

  logic                       in_acc;
  logic                       lb_in_range;
  logic [LAW-1:0]             in_lb_addr;
  logic                       new_pos;
  logic [CW-1:0]              cnt_next;
  logic [TRY_W-1:0]           tries_next;
  logic                       old_valid;
  logic                       old_drawn;
  logic                       last_emit;

  rng_ctl_t                   rng_ctl;
  logic                       rng_done;
  logic [SEED_W-1:0]          rng_value;
  logic                       mod_start;
  logic                       mod_done;
  logic [PW-1:0]              mod_res;

  logic                       home_re, home_we;
  logic [PW-1:0]              home_rdata;
  logic                       dr_we, dr_re;
  logic [PW-1:0]              dr_rdata;

  // Generator and modulo unit.
  woram_rng u_rng (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rng_ctl),
    .seed_i  (seed_q),
    .done_o  (rng_done),
    .value_o (rng_value)
  );

  woram_mod #(
    .PHYSICAL_BLOCKS (PHYSICAL_BLOCKS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (rng_value),
    .done_o  (mod_done),
    .res_o   (mod_res)
  );

  // Home map: read when a transaction is taken, written back at placement.
  // The two never fall in the same transaction step, so no forwarding.
  woram_ram #(
    .WIDTH (PW),
    .DEPTH (LOGICAL_BLOCKS)
  ) u_home_ram (
    .clk_i   (clk_i),
    .we_i    (home_we),
    .waddr_i (lb_addr_q),
    .wdata_i (home_d),
    .re_i    (home_re),
    .raddr_i (in_lb_addr),
    .rdata_o (home_rdata)
  );

  // Drawn positions in draw order.
  woram_ram #(
    .WIDTH (PW),
    .DEPTH (TARGET)
  ) u_drawn_ram (
    .clk_i   (clk_i),
    .we_i    (dr_we),
    .waddr_i (draw_cnt_q[IW-1:0]),
    .wdata_i (mod_res),
    .re_i    (dr_re),
    .raddr_i (emit_idx_q[IW-1:0]),
    .rdata_o (dr_rdata)
  );

  // Handshake decode.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign lb_in_range = 32'(in_data_i.logical_block) < LOGICAL_BLOCKS;
  assign in_lb_addr  = LAW'(in_data_i.logical_block);
  assign slot_free   = !out_valid_q || out_ready_i;

  // Sampling bookkeeping: a fresh position is one not drawn yet.
  assign new_pos    = !drawn_q[mod_res];
  assign cnt_next   = draw_cnt_q + CW'(new_pos);
  assign tries_next = tries_q + 1'b1;

  // Placement inputs: the old home and whether it was drawn again.
  assign old_valid  = map_valid_q[lb_addr_q];
  assign old_drawn  = old_valid && drawn_q[home_rdata];
  assign last_emit  = (CW'(emit_idx_q + 1'b1) == draw_cnt_q);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    lb_addr_d   = lb_addr_q;
    map_valid_d = map_valid_q;
    occupied_d  = occupied_q;
    drawn_d     = drawn_q;
    draw_cnt_d  = draw_cnt_q;
    emit_idx_d  = emit_idx_q;
    tries_d     = tries_q;
    ff_valid_d  = ff_valid_q;
    ff_d        = ff_q;
    have_d      = have_q;
    home_d      = home_q;
    out_d       = out_q;
    out_load    = 1'b0;
    rng_ctl     = '0;
    mod_start   = 1'b0;
    home_re     = 1'b0;
    home_we     = 1'b0;
    dr_we       = 1'b0;
    dr_re       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          lb_addr_d = in_lb_addr;
          unique case (in_data_i.op)
            OP_RESTART: begin
              rng_ctl.load = 1'b1;
              map_valid_d  = '0;
              occupied_d   = '0;
              draw_cnt_d   = '0;
            end
            OP_WRITE: begin
              if (lb_in_range) begin
                home_re       = 1'b1;
                drawn_d       = '0;
                draw_cnt_d    = '0;
                tries_d       = '0;
                ff_valid_d    = 1'b0;
                rng_ctl.start = 1'b1;
                state_d       = S_DRAW_RNG;
              end
            end
            OP_LOOKUP: begin
              if (lb_in_range) begin
                home_re = 1'b1;
                state_d = S_LOOK;
              end
            end
            default: ;
          endcase
        end
      end

      // Lookup answer, once the output register has room.
      S_LOOK: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_d.position = map_valid_q[lb_addr_q] ? POS_W'(home_rdata) : '0;
          out_d.action   = ACT_LOOKUP;
          out_d.nonce    = '0;
          out_d.mapped   = map_valid_q[lb_addr_q];
          out_d.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end

      S_DRAW_RNG: begin
        if (rng_done) begin
          mod_start = 1'b1;
          state_d   = S_DRAW_MOD;
        end
      end

      // Keep a fresh position, note the first free one, and either draw
      // again or move on to placement.
      S_DRAW_MOD: begin
        if (mod_done) begin
          tries_d = tries_next;
          if (new_pos) begin
            dr_we            = 1'b1;
            drawn_d[mod_res] = 1'b1;
            draw_cnt_d       = cnt_next;
            if (!occupied_q[mod_res] && !ff_valid_q) begin
              ff_valid_d = 1'b1;
              ff_d       = mod_res;
            end
          end
          if ((cnt_next == CW'(TARGET)) || (tries_next == TRY_W'(DRAW_LIMIT))) begin
            state_d = S_PLACE;
          end else begin
            rng_ctl.start = 1'b1;
            state_d       = S_DRAW_RNG;
          end
        end
      end

      // The old home stays if it was drawn; otherwise the first free drawn
      // position becomes home and frees the old one; if none, no change.
      S_PLACE: begin
        priority if (old_drawn) begin
          have_d = 1'b1;
          home_d = home_rdata;
        end else if (ff_valid_q) begin
          have_d = 1'b1;
          home_d = ff_q;
          if (old_valid) begin
            occupied_d[home_rdata] = 1'b0;
          end
        end else begin
          have_d = 1'b0;
        end
        if (have_d) begin
          occupied_d[home_d]     = 1'b1;
          map_valid_d[lb_addr_q] = 1'b1;
          home_we                = 1'b1;
        end
        emit_idx_d = '0;
        state_d    = S_EMIT_RD;
      end

      S_EMIT_RD: begin
        dr_re         = 1'b1;
        rng_ctl.start = 1'b1;
        state_d       = S_EMIT_RNG;
      end

      S_EMIT_RNG: begin
        if (rng_done) begin
          state_d = S_EMIT_OUT;
        end
      end

      // One result per drawn position, each with a fresh nonce.
      S_EMIT_OUT: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_d.position = POS_W'(dr_rdata);
          priority if (have_q && (dr_rdata == home_q)) begin
            out_d.action = ACT_NEW;
          end else if (occupied_q[dr_rdata]) begin
            out_d.action = ACT_KEEP;
          end else begin
            out_d.action = ACT_ZERO;
          end
          out_d.nonce  = rng_value;
          out_d.mapped = 1'b0;
          out_d.last   = last_emit;
          if (last_emit) begin
            state_d = S_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
            state_d    = S_EMIT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output register valid.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= SEED_RESET;
      map_valid_q <= '0;
      occupied_q  <= '0;
      drawn_q     <= '0;
      draw_cnt_q  <= '0;
      emit_idx_q  <= '0;
      tries_q     <= '0;
      ff_valid_q  <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      map_valid_q <= map_valid_d;
      occupied_q  <= occupied_d;
      drawn_q     <= drawn_d;
      draw_cnt_q  <= draw_cnt_d;
      emit_idx_q  <= emit_idx_d;
      tries_q     <= tries_d;
      ff_valid_q  <= ff_valid_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        seed_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lb_addr_q <= lb_addr_d;
    ff_q      <= ff_d;
    home_q    <= home_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every mapped logical block owns exactly one occupied position.
  a_occ_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occupied_q) == $countones(map_valid_q))
    else $error("occupancy count differs from mapped block count");

  // The sampling count never passes the draw target.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_cnt_q <= CW'(TARGET))
    else $error("drawn position count exceeds target");

  // Results are only issued for positions that were drawn.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_OUT) |-> (emit_idx_q < draw_cnt_q))
    else $error("result index beyond drawn positions");

  // The modulo unit returns a valid physical position.
  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (32'(mod_res) < PHYSICAL_BLOCKS))
    else $error("drawn position out of range");

endmodule

[sv/woram_ram.sv]
// ----------------------------------------------------------------------------
// woram_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds its
// value until the next read.
// ----------------------------------------------------------------------------
module woram_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/woram_rng.sv]
// ----------------------------------------------------------------------------
// woram_rng: xorshift64* generator with a shared 32x32 multiplier
// A start advances the state and forms the low 64 bits of state * constant
// from three partial products, one per cycle; done pulses when ready.
// ----------------------------------------------------------------------------
module woram_rng (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  woram_pkg::rng_ctl_t           ctl_i,
  input  logic [woram_pkg::SEED_W-1:0]  seed_i,
  output logic                          done_o,
  output logic [woram_pkg::SEED_W-1:0]  value_o
);
  import woram_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_LOW     = 2'd1;
  localparam logic [1:0] ST_CROSS_A = 2'd2;
  localparam logic [1:0] ST_CROSS_B = 2'd3;

  logic [1:0]        step_q;
  logic              done_q;
  logic [SEED_W-1:0] x_q;
  logic [SEED_W-1:0] acc_q;
  logic [HALF_W-1:0] cross_q;
  logic [SEED_W-1:0] value_q;
  logic [SEED_W-1:0] x_shift;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [SEED_W-1:0] prod;

  // One xorshift step of the state.
  always_comb begin
    x_shift = x_q ^ (x_q >> SHIFT_A);
    x_shift = x_shift ^ (x_shift << SHIFT_B);
    x_shift = x_shift ^ (x_shift >> SHIFT_C);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (step_q)
      ST_CROSS_A: begin
        mul_a = x_q[SEED_W-1:HALF_W];
        mul_b = MULT_CONST[HALF_W-1:0];
      end
      ST_CROSS_B: begin
        mul_a = x_q[HALF_W-1:0];
        mul_b = MULT_CONST[SEED_W-1:HALF_W];
      end
      default: begin
        mul_a = x_q[HALF_W-1:0];
        mul_b = MULT_CONST[HALF_W-1:0];
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Generator state and sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= SEED_RESET;
      step_q <= ST_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (step_q)
        ST_IDLE: begin
          if (ctl_i.load) begin
            x_q <= seed_i;
          end else if (ctl_i.start) begin
            x_q    <= x_shift;
            step_q <= ST_LOW;
          end
        end
        ST_LOW:     step_q <= ST_CROSS_A;
        ST_CROSS_A: step_q <= ST_CROSS_B;
        ST_CROSS_B: begin
          step_q <= ST_IDLE;
          done_q <= 1'b1;
        end
        default:    step_q <= ST_IDLE;
      endcase
    end
  end

  // Partial products; the cross terms only reach the upper half.
  always_ff @(posedge clk_i) begin
    unique case (step_q)
      ST_LOW:     acc_q   <= prod;
      ST_CROSS_A: cross_q <= prod[HALF_W-1:0];
      ST_CROSS_B: value_q <= acc_q + {cross_q + prod[HALF_W-1:0], {HALF_W{1'b0}}};
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

[sv/woram_mod.sv]
// ----------------------------------------------------------------------------
// woram_mod: residue of a 64-bit word modulo the physical block count
// Restoring reduction, one byte per cycle from the most significant end;
// done pulses after the last byte.
// ----------------------------------------------------------------------------
module woram_mod #(
  parameter int unsigned PHYSICAL_BLOCKS = woram_pkg::PHYSICAL_BLOCKS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [woram_pkg::SEED_W-1:0]         value_i,
  output logic                                 done_o,
  output logic [$clog2(PHYSICAL_BLOCKS)-1:0]   res_o
);
  import woram_pkg::*;

  localparam int unsigned RW = $clog2(PHYSICAL_BLOCKS) + 1;

  logic              busy_q;
  logic              done_q;
  logic [DCW-1:0]    cnt_q;
  logic [SEED_W-1:0] sh_q;
  logic [RW-1:0]     r_q;
  logic [RW-1:0]     r_v;

  // Shift in one byte, subtracting the modulus whenever the partial
  // remainder reaches it.
  always_comb begin
    r_v = r_q;
    for (int i = 0; i < DIGIT_W; i++) begin
      r_v = {r_v[RW-2:0], sh_q[SEED_W-1-i]};
      if (r_v >= RW'(PHYSICAL_BLOCKS)) begin
        r_v = r_v - RW'(PHYSICAL_BLOCKS);
      end
    end
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCW'(DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= value_i;
      r_q  <= '0;
    end else if (busy_q) begin
      sh_q <= sh_q << DIGIT_W;
      r_q  <= r_v;
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q[RW-2:0];

endmodule

[tb/write_only_oram_placement_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// write_only_oram_placement_checker: result checker for the placement engine
// Watches the seed, input and result channels, keeps its own copy of the
// generator, home map and occupancy, predicts every result transaction and
// compares each one that arrives with the oldest prediction.
// ----------------------------------------------------------------------------
module write_only_oram_placement_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [woram_pkg::SEED_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  woram_pkg::in_item_t          in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  woram_pkg::out_item_t         out_data_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o
);
  import woram_pkg::*;

  localparam int unsigned NLB    = LOGICAL_BLOCKS_DEF;
  localparam int unsigned NPB    = PHYSICAL_BLOCKS_DEF;
  localparam int unsigned NTOUCH = TOUCH_COUNT_DEF;
  localparam int unsigned TARGET = (NTOUCH < NPB) ? NTOUCH : NPB;

  // Shadow copy of the engine state.
  logic [SEED_W-1:0] seed_reg;
  logic [SEED_W-1:0] gen_state;
  logic              home_valid [NLB];
  logic [POS_W-1:0]  home_pos   [NLB];
  logic              in_use     [NPB];

  // Results still owed by the engine, oldest first.
  out_item_t expected_results [$];

  // One xorshift64* step; returns the scrambled output.
  function automatic logic [SEED_W-1:0] next_nonce();
    logic [SEED_W-1:0] x;
    x = gen_state;
    x ^= x >> SHIFT_A;
    x ^= x << SHIFT_B;
    x ^= x >> SHIFT_C;
    gen_state = x;
    return x * MULT_CONST;
  endfunction

  task automatic clear_placement();
    for (int i = 0; i < NLB; i++) begin
      home_valid[i] = 1'b0;
      home_pos[i]   = '0;
    end
    for (int i = 0; i < NPB; i++) begin
      in_use[i] = 1'b0;
    end
  endtask

  // Draw distinct positions, choose the new home and queue one result per
  // drawn position in draw order.
  task automatic predict_write(input logic [LB_W-1:0] lb);
    int unsigned       drawn [NTOUCH];
    int unsigned       count;
    int unsigned       tries;
    int unsigned       p;
    int unsigned       home;
    logic              dup;
    logic              have_home;
    logic [SEED_W-1:0] r;
    out_item_t         res;
    count = 0;
    tries = 0;
    while (count < TARGET && tries < DRAW_LIMIT) begin
      r   = next_nonce();
      p   = 32'(r % NPB);
      dup = 1'b0;
      for (int i = 0; i < count; i++) begin
        if (drawn[i] == p) dup = 1'b1;
      end
      if (!dup) begin
        drawn[count] = p;
        count++;
      end
      tries++;
    end

    // The old home wins if it was drawn again.
    have_home = 1'b0;
    home      = 0;
    if (home_valid[lb]) begin
      for (int i = 0; i < count; i++) begin
        if (!have_home && drawn[i] == home_pos[lb]) begin
          home      = drawn[i];
          have_home = 1'b1;
        end
      end
    end

    // Otherwise take the first free drawn position and free the old home.
    if (!have_home) begin
      for (int i = 0; i < count; i++) begin
        if (!have_home && !in_use[drawn[i]]) begin
          home      = drawn[i];
          have_home = 1'b1;
        end
      end
      if (have_home && home_valid[lb]) in_use[home_pos[lb]] = 1'b0;
    end
    if (have_home) begin
      in_use[home]   = 1'b1;
      home_pos[lb]   = POS_W'(home);
      home_valid[lb] = 1'b1;
    end

    for (int i = 0; i < count; i++) begin
      res.position = POS_W'(drawn[i]);
      if (have_home && drawn[i] == home) begin
        res.action = ACT_NEW;
      end else if (in_use[drawn[i]]) begin
        res.action = ACT_KEEP;
      end else begin
        res.action = ACT_ZERO;
      end
      res.nonce  = next_nonce();
      res.mapped = 1'b0;
      res.last   = (i + 1 == count);
      expected_results.push_back(res);
    end
  endtask

  task automatic predict_item(input in_item_t item);
    out_item_t res;
    case (item.op)
      OP_RESTART: begin
        gen_state = seed_reg;
        clear_placement();
      end
      OP_WRITE: begin
        if (item.logical_block < NLB) predict_write(item.logical_block);
      end
      OP_LOOKUP: begin
        if (item.logical_block < NLB) begin
          res.position = home_valid[item.logical_block] ? home_pos[item.logical_block] : '0;
          res.action   = ACT_LOOKUP;
          res.nonce    = '0;
          res.mapped   = home_valid[item.logical_block];
          res.last     = 1'b1;
          expected_results.push_back(res);
        end
      end
      default: begin
        // The unused code is dropped without any effect.
      end
    endcase
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    logic      bad;
    if (expected_results.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10) begin
        $display("%0t: unexpected result: pos %0d act %0d nonce %h mapped %b last %b",
                 $realtime, got.position, got.action, got.nonce, got.mapped, got.last);
      end
    end else begin
      want = expected_results.pop_front();
      checked_o++;
      bad = (got.position !== want.position) || (got.action !== want.action) ||
            (got.nonce !== want.nonce) || (got.mapped !== want.mapped) ||
            (got.last !== want.last);
      if (bad) begin
        mismatch_count_o++;
        if (mismatch_count_o <= 10) begin
          $display("%0t: result %0d expected pos %0d act %0d nonce %h mapped %b last %b",
                   $realtime, checked_o, want.position, want.action, want.nonce,
                   want.mapped, want.last);
          $display("%0t: result %0d got      pos %0d act %0d nonce %h mapped %b last %b",
                   $realtime, checked_o, got.position, got.action, got.nonce,
                   got.mapped, got.last);
        end
      end
    end
  endtask

  // Follow every transaction; inputs are predicted before results are
  // compared so that a same-edge pair is handled in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_reg  = SEED_RESET;
      gen_state = SEED_RESET;
      clear_placement();
      expected_results.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      checked_o        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) seed_reg = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      if (out_valid_i && out_ready_i) compare_result(out_data_i);
      pending_o = expected_results.size();
    end
  end

endmodule

[tb/write_only_oram_placement_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// write_only_oram_placement_test: stimulus and verdict for the placement engine
// Runs directed writes and lookups, a zero-seed phase, then random traffic
// under an all-ones and a random seed, with random idling on both sides, a
// long result stall and a full drain pause. Checking is done by the checker.
// ----------------------------------------------------------------------------
module write_only_oram_placement_test;
  import woram_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
  localparam int unsigned     IDLE_PERCENT   = 29;
  localparam int unsigned     HOLD_CYCLES    = 400;
  localparam int unsigned     SETTLE_CYCLES  = 40;
  localparam int unsigned     WATCHDOG_LIMIT = 60000;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [SEED_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  // Idling control shared by the sender and the receiver.
  logic        steady     = 1'b0;
  int unsigned hold_asks  = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned idle_count = 0;

  int unsigned n_writes   = 0;
  int unsigned n_lookups  = 0;
  int unsigned n_restarts = 0;
  int unsigned n_ignored  = 0;

  write_only_oram_placement dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  write_only_oram_placement_checker result_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, a calm stretch, and long hold-offs on request.
  always @(posedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen   <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Offer one input transaction, after an optional random gap.
  task automatic send_item(input logic [OP_W-1:0] op_code, input logic [LB_W-1:0] block);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 200) : $urandom_range(1, 4);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{op: op_code, logical_block: block};
    do @(posedge clk_i); while (!in_ready_o);
    case (op_code)
      OP_RESTART: n_restarts++;
      OP_WRITE:   n_writes++;
      OP_LOOKUP:  n_lookups++;
      default:    n_ignored++;
    endcase
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly writes and lookups, with a few restarts and dropped codes.
  task automatic run_random(input int unsigned count, input int unsigned calm_count,
                            input int hold_at, input int pause_at);
    int unsigned      pick;
    logic [OP_W-1:0]  op_code;
    for (int k = 0; k < count; k++) begin
      steady <= (k < calm_count);
      if (k == hold_at) hold_asks <= hold_asks + 1;
      if (k == pause_at) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        op_code = OP_RESTART;
      end else if (pick < 8) begin
        op_code = OP_UNUSED;
      end else if (pick < 68) begin
        op_code = OP_WRITE;
      end else begin
        op_code = OP_LOOKUP;
      end
      send_item(op_code, LB_W'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed traffic on the reset seed: unmapped lookups, rewrites of the
    // same block, a dropped code, a full map and a restart that clears it.
    send_item(OP_LOOKUP, 3'd0);
    send_item(OP_WRITE, 3'd0);
    send_item(OP_LOOKUP, 3'd0);
    send_item(OP_WRITE, 3'd7);
    send_item(OP_LOOKUP, 3'd7);
    send_item(OP_WRITE, 3'd0);
    send_item(OP_LOOKUP, 3'd0);
    send_item(OP_UNUSED, 3'd5);
    send_item(OP_LOOKUP, 3'd3);
    send_item(OP_WRITE, 3'd3);
    send_item(OP_WRITE, 3'd5);
    send_item(OP_WRITE, 3'd1);
    send_item(OP_WRITE, 3'd2);
    send_item(OP_WRITE, 3'd4);
    send_item(OP_WRITE, 3'd6);
    send_item(OP_LOOKUP, 3'd6);
    send_item(OP_RESTART, 3'd0);
    send_item(OP_LOOKUP, 3'd7);
    send_item(OP_WRITE, 3'd7);
    wait_idle();

    // A zero seed draws position 0 forever: the draw limit is hit, and a
    // second block finds no free position and stays unmapped.
    write_seed('0);
    send_item(OP_RESTART, 3'd2);
    send_item(OP_WRITE, 3'd0);
    send_item(OP_WRITE, 3'd1);
    send_item(OP_LOOKUP, 3'd1);
    send_item(OP_WRITE, 3'd0);
    send_item(OP_LOOKUP, 3'd0);
    wait_idle();

    // All-ones seed: a calm stretch, then random idling and a long stall.
    write_seed('1);
    send_item(OP_RESTART, 3'd0);
    run_random(110, 50, 80, -1);
    wait_idle();

    // Random seed, with a pause until every result is back.
    write_seed({$urandom(), $urandom()});
    send_item(OP_RESTART, 3'd0);
    run_random(110, 0, -1, 55);
    wait_idle();

    @(negedge clk_i);
    $display("Covered %0d input transactions: %0d writes, %0d lookups, %0d restarts, %0d dropped,",
             n_writes + n_lookups + n_restarts + n_ignored, n_writes, n_lookups, n_restarts,
             n_ignored);
    $display("over four seed values; %0d result transactions checked, %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
